/* rtl/can_arb_pkg.sv */
// ----------------------------------------------------------------------------
// can_arb_pkg
// Shared widths, event and fault codes, sequencer types and word structs for
// the CAN identifier arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package can_arb_pkg;

    // field widths of the event and result words
    localparam int KIND_W       = 3;
    localparam int FRAME_ID_W   = 29;
    localparam int NODE_W       = 4;
    localparam int FRAME_BITS_W = 8;
    localparam int WAIT_W       = 8;
    localparam int FAULT_W      = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int ERR_BITS_W = 8;
    localparam int ARB_DLY_W  = 4;

    localparam logic [ERR_BITS_W-1:0] ERROR_FRAME_RESET = 8'd12;
    localparam logic [ARB_DLY_W-1:0]  ARB_DELAY_RESET   = 4'd1;

    // register index taken from the word address
    localparam logic REG_ERROR_FRAME = 1'b0;
    localparam logic REG_ARB_DELAY   = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_REGISTER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WITHDRAW  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARBITRATE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEEN      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR_END = 3'd6;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_DUAL = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_FULL = 2'd2;

    // sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } arb_state_t;

    typedef enum logic [1:0] {
        SCAN_DROP_ID,
        SCAN_DROP_MARK,
        SCAN_ARB
    } scan_mode_t;

    // configuration values
    typedef struct packed {
        logic [ERR_BITS_W-1:0] error_frame_bits;
        logic [ARB_DLY_W-1:0]  arbitration_delay_bits;
    } cfg_t;

    // result word
    typedef struct packed {
        logic                  grant_valid;
        logic [FRAME_ID_W-1:0] grant_id;
        logic [NODE_W-1:0]     grant_node;
        logic                  done_valid;
        logic [FRAME_ID_W-1:0] done_id;
        logic [NODE_W-1:0]     done_node;
        logic [WAIT_W-1:0]     wait_bits;
        logic                  forward;
        logic                  bus_idle;
        logic [FAULT_W-1:0]    fault;
    } res_t;

endpackage

`default_nettype wire

/* rtl/can_arb_evt_if.sv */
// ----------------------------------------------------------------------------
// can_arb_evt_if
// Event channel: valid/ready handshake with the bus event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface can_arb_evt_if import can_arb_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [FRAME_ID_W-1:0]   frame_id;
    logic [NODE_W-1:0]       node;
    logic                    remote;
    logic [FRAME_BITS_W-1:0] frame_bits;

    modport source (output valid, kind, frame_id, node, remote, frame_bits, input ready);
    modport sink   (input valid, kind, frame_id, node, remote, frame_bits, output ready);

endinterface

`default_nettype wire

/* rtl/can_arb_res_if.sv */
// ----------------------------------------------------------------------------
// can_arb_res_if
// Result channel: valid/ready handshake with the arbitration result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface can_arb_res_if import can_arb_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  grant_valid;
    logic [FRAME_ID_W-1:0] grant_id;
    logic [NODE_W-1:0]     grant_node;
    logic                  done_valid;
    logic [FRAME_ID_W-1:0] done_id;
    logic [NODE_W-1:0]     done_node;
    logic [WAIT_W-1:0]     wait_bits;
    logic                  forward;
    logic                  bus_idle;
    logic [FAULT_W-1:0]    fault;

    modport source (
        output valid, grant_valid, grant_id, grant_node, done_valid, done_id,
               done_node, wait_bits, forward, bus_idle, fault,
        input  ready
    );
    modport sink (
        input  valid, grant_valid, grant_id, grant_node, done_valid, done_id,
               done_node, wait_bits, forward, bus_idle, fault,
        output ready
    );

endinterface

`default_nettype wire

/* rtl/can_arb_ram.sv */
// ----------------------------------------------------------------------------
// can_arb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module can_arb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/can_arb_cfg.sv */
// ----------------------------------------------------------------------------
// can_arb_cfg
// APB register file for the error frame length and the arbitration delay.
// ----------------------------------------------------------------------------
`default_nettype none

module can_arb_cfg import can_arb_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ERROR_FRAME: cfg_next.error_frame_bits = pwdata[ERR_BITS_W-1:0];
                REG_ARB_DELAY:   cfg_next.arbitration_delay_bits = pwdata[ARB_DLY_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_frame_bits       <= ERROR_FRAME_RESET;
            cfg_reg.arbitration_delay_bits <= ARB_DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_ERROR_FRAME: prdata = APB_DATA_W'(cfg_reg.error_frame_bits);
            REG_ARB_DELAY:   prdata = APB_DATA_W'(cfg_reg.arbitration_delay_bits);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/can_bus_priority_arbiter_unit.sv */
// ----------------------------------------------------------------------------
// can_bus_priority_arbiter_unit
// CAN identifier arbiter: pending send requests live in a RAM table kept in
// arrival order; a sequencer scans it to arbitrate and to delete entries.
// ----------------------------------------------------------------------------
// order: register, frame seen, error and ignored words give their result without a
//   table pass; withdraw, arbitrate and error end make one pass over the table, and
//   frame end makes a delete pass and then an arbitration pass
// throughput: one word in flight; the table scan (one RAM read per entry) sets it,
//   and the next word is taken as soon as the result moves to the output register
// reset: table empty, bus idle, error frame 12 bit times, arbitration delay 1;
//   the table RAM needs no clearing pass
`default_nettype none

module can_bus_priority_arbiter_unit import can_arb_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int NODE_COUNT  = 16,
    parameter int ID_WIDTH    = 29
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    can_arb_evt_if.sink                evt,
    can_arb_res_if.source              res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = ID_WIDTH + NODE_W + 1;

    cfg_t cfg;

    // control state
    arb_state_t             state_reg, state_next;
    scan_mode_t             mode_reg, mode_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TABLE_DEPTH-1:0] mark_reg, mark_next;
    logic                   idle_flag_reg, idle_flag_next;
    logic                   error_active_reg, error_active_next;
    logic                   frame_pending_reg, frame_pending_next;
    logic [ID_WIDTH-1:0]    cur_ident_reg, cur_ident_next;
    logic [NODE_W-1:0]      cur_node_reg, cur_node_next;
    logic                   cur_valid_reg, cur_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          iss_reg, iss_next;
    logic [CW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic                   pv_reg, pv_next;
    logic                   arb_after_reg, arb_after_next;
    logic                   found_reg, found_next;
    logic                   have_data_reg, have_data_next;
    logic                   multi_reg, multi_next;

    // payload state
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic [ID_WIDTH-1:0] best_reg, best_next;
    logic [NODE_W-1:0]   gnode_reg, gnode_next;
    logic [ID_WIDTH-1:0] wid_reg, wid_next;
    res_t                acc_reg, acc_next;
    res_t                out_reg, out_next;

    // table RAM ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic                   accept;
    logic                   out_free;
    logic                   scan_done;
    logic                   needs_scan;
    logic                   node_ok;
    logic [ID_WIDTH-1:0]    evt_ident;
    logic [ID_WIDTH-1:0]    r_ident;
    logic [NODE_W-1:0]      r_node;
    logic                   r_remote;
    logic [TABLE_DEPTH-1:0] valid_mask;

    can_arb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // entry word: remote, node, identifier
    can_arb_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_ident  = ram_rdata[ID_WIDTH-1:0];
    assign r_node   = ram_rdata[ID_WIDTH +: NODE_W];
    assign r_remote = ram_rdata[EW-1];

    assign evt_ident = evt.frame_id[ID_WIDTH-1:0];
    assign node_ok   = int'(evt.node) < NODE_COUNT;
    assign accept    = evt.valid && evt.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign scan_done = (iss_reg == count_reg) && !pv_reg;

    // events that need a pass over the table
    always_comb
    begin
        case (evt.kind)
            KIND_WITHDRAW, KIND_ARBITRATE: needs_scan = 1'b1;
            KIND_END:                      needs_scan = frame_pending_reg;
            KIND_ERROR_END:                needs_scan = error_active_reg;
            default:                       needs_scan = 1'b0;
        endcase
    end

    // occupied table positions
    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            valid_mask[k] = CW'(k) < count_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (scan_done && !(mode_reg != SCAN_ARB && arb_after_reg))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign evt.ready = state_reg == ST_IDLE;

    // datapath and table updates
    always_comb
    begin
        mode_next          = mode_reg;
        count_next         = count_reg;
        mark_next          = mark_reg;
        idle_flag_next     = idle_flag_reg;
        error_active_next  = error_active_reg;
        frame_pending_next = frame_pending_reg;
        cur_ident_next     = cur_ident_reg;
        cur_node_next      = cur_node_reg;
        cur_valid_next     = cur_valid_reg;
        iss_next           = iss_reg;
        wr_ptr_next        = wr_ptr_reg;
        pv_next            = pv_reg;
        arb_after_next     = arb_after_reg;
        found_next         = found_reg;
        have_data_next     = have_data_reg;
        multi_next         = multi_reg;
        pidx_next          = pidx_reg;
        best_next          = best_reg;
        gnode_next         = gnode_reg;
        wid_next           = wid_reg;
        acc_next           = acc_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && !res.ready;

        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = iss_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    acc_next    = '0;
                    iss_next    = '0;
                    wr_ptr_next = '0;
                    pv_next     = 1'b0;
                    found_next  = 1'b0;
                    have_data_next = 1'b0;
                    multi_next  = 1'b0;
                    arb_after_next = 1'b0;
                    wid_next    = evt_ident;
                    case (evt.kind)
                        KIND_REGISTER:
                        begin
                            if (node_ok)
                            begin
                                if (count_reg == CW'(TABLE_DEPTH))
                                begin
                                    acc_next.fault = FAULT_FULL;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = count_reg[IW-1:0];
                                    ram_wdata = {evt.remote, evt.node, evt_ident};
                                    mark_next[count_reg[IW-1:0]] = 1'b0;
                                    count_next = count_reg + 1'b1;
                                    if (idle_flag_reg)
                                    begin
                                        acc_next.wait_bits =
                                            WAIT_W'(cfg.arbitration_delay_bits);
                                        idle_flag_next = 1'b0;
                                    end
                                end
                            end
                        end
                        KIND_WITHDRAW:
                        begin
                            mode_next = SCAN_DROP_ID;
                        end
                        KIND_ARBITRATE:
                        begin
                            mode_next = SCAN_ARB;
                            mark_next = '0;
                        end
                        KIND_SEEN:
                        begin
                            frame_pending_next = 1'b1;
                            acc_next.wait_bits = evt.frame_bits;
                            acc_next.forward   = 1'b1;
                        end
                        KIND_END:
                        begin
                            if (frame_pending_reg)
                            begin
                                if (cur_valid_reg)
                                begin
                                    acc_next.done_valid = 1'b1;
                                    acc_next.done_id    = FRAME_ID_W'(cur_ident_reg);
                                    acc_next.done_node  = cur_node_reg;
                                end
                                mode_next          = SCAN_DROP_MARK;
                                arb_after_next     = 1'b1;
                                error_active_next  = 1'b0;
                                frame_pending_next = 1'b0;
                            end
                        end
                        KIND_ERROR:
                        begin
                            frame_pending_next = 1'b0;
                            if (!error_active_reg)
                            begin
                                error_active_next  = 1'b1;
                                acc_next.wait_bits = cfg.error_frame_bits;
                                acc_next.forward   = 1'b1;
                            end
                        end
                        KIND_ERROR_END:
                        begin
                            if (error_active_reg)
                            begin
                                frame_pending_next = 1'b0;
                                error_active_next  = 1'b0;
                                mark_next          = '0;
                                mode_next          = SCAN_ARB;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // read side: one entry a cycle
                if (iss_reg != count_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = iss_reg[IW-1:0];
                    iss_next  = iss_reg + 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end

                // process the entry read last cycle
                if (pv_reg)
                begin
                    if (mode_reg == SCAN_ARB)
                    begin
                        if (!found_reg || r_ident < best_reg)
                        begin
                            // new lowest identifier restarts the marks
                            best_next      = r_ident;
                            gnode_next     = r_node;
                            found_next     = 1'b1;
                            have_data_next = !r_remote;
                            multi_next     = 1'b0;
                            mark_next      = '0;
                            mark_next[pidx_reg] = 1'b1;
                        end
                        else if (r_ident == best_reg)
                        begin
                            mark_next[pidx_reg] = 1'b1;
                            if (!r_remote)
                            begin
                                if (!have_data_reg)
                                begin
                                    gnode_next = r_node;
                                end
                                multi_next     = multi_reg || have_data_reg;
                                have_data_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // compaction: kept entries move down behind the reads
                        if (!((mode_reg == SCAN_DROP_ID) ? (r_ident == wid_reg)
                                                         : mark_reg[pidx_reg]))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = wr_ptr_reg[IW-1:0];
                            ram_wdata = ram_rdata;
                            mark_next[wr_ptr_reg[IW-1:0]] = mark_reg[pidx_reg];
                            wr_ptr_next = wr_ptr_reg + 1'b1;
                        end
                    end
                end

                // end of pass
                if (scan_done)
                begin
                    if (mode_reg == SCAN_ARB)
                    begin
                        if (!found_reg)
                        begin
                            idle_flag_next = 1'b1;
                            cur_valid_next = 1'b0;
                            cur_ident_next = '1;
                            cur_node_next  = '0;
                        end
                        else
                        begin
                            idle_flag_next       = 1'b0;
                            cur_valid_next       = 1'b1;
                            cur_ident_next       = best_reg;
                            cur_node_next        = gnode_reg;
                            acc_next.grant_valid = 1'b1;
                            acc_next.grant_id    = FRAME_ID_W'(best_reg);
                            acc_next.grant_node  = gnode_reg;
                            if (multi_reg)
                            begin
                                acc_next.fault = FAULT_DUAL;
                            end
                        end
                    end
                    else
                    begin
                        count_next = wr_ptr_reg;
                        for (int k = 0; k < TABLE_DEPTH; k++)
                        begin
                            if (CW'(k) >= wr_ptr_reg)
                            begin
                                mark_next[k] = 1'b0;
                            end
                        end
                        if (arb_after_reg)
                        begin
                            mode_next      = SCAN_ARB;
                            mark_next      = '0;
                            iss_next       = '0;
                            pv_next        = 1'b0;
                            found_next     = 1'b0;
                            have_data_next = 1'b0;
                            multi_next     = 1'b0;
                        end
                    end
                end
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    out_next          = acc_reg;
                    out_next.bus_idle = idle_flag_reg;
                    out_valid_next    = 1'b1;
                end
            end

            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= SCAN_ARB;
            count_reg         <= '0;
            mark_reg          <= '0;
            idle_flag_reg     <= 1'b1;
            error_active_reg  <= 1'b0;
            frame_pending_reg <= 1'b0;
            cur_ident_reg     <= '1;
            cur_node_reg      <= '0;
            cur_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            iss_reg           <= '0;
            wr_ptr_reg        <= '0;
            pv_reg            <= 1'b0;
            arb_after_reg     <= 1'b0;
            found_reg         <= 1'b0;
            have_data_reg     <= 1'b0;
            multi_reg         <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            count_reg         <= count_next;
            mark_reg          <= mark_next;
            idle_flag_reg     <= idle_flag_next;
            error_active_reg  <= error_active_next;
            frame_pending_reg <= frame_pending_next;
            cur_ident_reg     <= cur_ident_next;
            cur_node_reg      <= cur_node_next;
            cur_valid_reg     <= cur_valid_next;
            out_valid_reg     <= out_valid_next;
            iss_reg           <= iss_next;
            wr_ptr_reg        <= wr_ptr_next;
            pv_reg            <= pv_next;
            arb_after_reg     <= arb_after_next;
            found_reg         <= found_next;
            have_data_reg     <= have_data_next;
            multi_reg         <= multi_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        best_reg  <= best_next;
        gnode_reg <= gnode_next;
        wid_reg   <= wid_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    // result channel
    assign res.valid       = out_valid_reg;
    assign res.grant_valid = out_reg.grant_valid;
    assign res.grant_id    = out_reg.grant_id;
    assign res.grant_node  = out_reg.grant_node;
    assign res.done_valid  = out_reg.done_valid;
    assign res.done_id     = out_reg.done_id;
    assign res.done_node   = out_reg.done_node;
    assign res.wait_bits   = out_reg.wait_bits;
    assign res.forward     = out_reg.forward;
    assign res.bus_idle    = out_reg.bus_idle;
    assign res.fault       = out_reg.fault;

    // table fill never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("table count beyond depth");

    // marks only sit on occupied positions outside a pass
    a_marks_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SCAN |-> (mark_reg & ~valid_mask) == '0)
        else $error("mark on empty table position");

    // compaction writes never overtake the read pointer
    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && ram_we |-> ram_waddr <= pidx_reg)
        else $error("compaction write ahead of read");

    // a granted bus is never reported idle
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.grant_valid |-> !res.bus_idle)
        else $error("grant with idle bus");

    // dual sender fault only comes with a grant
    a_dual_has_grant: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.fault == FAULT_DUAL |-> res.grant_valid)
        else $error("dual sender fault without grant");

endmodule

`default_nettype wire
